// ----- hdl/mtnc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtnc_pkg
// Shared types, codes and character helpers of the markup tag nesting checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mtnc_pkg;

  localparam int unsigned MAX_NAME_DEF    = 32;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_OPEN     = 4'd1;
  localparam logic [3:0] ERR_ATTR     = 4'd2;
  localparam logic [3:0] ERR_NOQUOTE  = 4'd3;
  localparam logic [3:0] ERR_GTVAL    = 4'd4;
  localparam logic [3:0] ERR_CLOSE    = 4'd5;
  localparam logic [3:0] ERR_MISMATCH = 4'd6;
  localparam logic [3:0] ERR_UNDER    = 4'd7;
  localparam logic [3:0] ERR_OVER     = 4'd8;
  localparam logic [3:0] ERR_LONG     = 4'd9;

  localparam logic [2:0] PC_TEXT  = 3'd0;
  localparam logic [2:0] PC_TAG   = 3'd1;
  localparam logic [2:0] PC_OPEN  = 3'd2;
  localparam logic [2:0] PC_ATTR  = 3'd3;
  localparam logic [2:0] PC_QUOTE = 3'd4;
  localparam logic [2:0] PC_VALUE = 3'd5;
  localparam logic [2:0] PC_CLOSE = 3'd6;
  localparam logic [2:0] PC_ERR   = 3'd7;

  typedef enum logic [7:0] {
    PH_TEXT  = 8'b0000_0001,
    PH_TAG   = 8'b0000_0010,
    PH_OPEN  = 8'b0000_0100,
    PH_ATTR  = 8'b0000_1000,
    PH_QUOTE = 8'b0001_0000,
    PH_VALUE = 8'b0010_0000,
    PH_CLOSE = 8'b0100_0000,
    PH_ERR   = 8'b1000_0000
  } phase_e;

  // per-byte control handed from the automaton to the compare stage
  typedef struct packed {
    logic cmp;       // close-name byte to compare with the top entry
    logic pop;       // closing '>' that pops the top entry
    logic top_zero;  // stack empty when the byte arrived
  } ctl_t;

  function automatic logic [2:0] phase_code(input phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_TEXT:  code = PC_TEXT;
      PH_TAG:   code = PC_TAG;
      PH_OPEN:  code = PC_OPEN;
      PH_ATTR:  code = PC_ATTR;
      PH_QUOTE: code = PC_QUOTE;
      PH_VALUE: code = PC_VALUE;
      PH_CLOSE: code = PC_CLOSE;
      default:  code = PC_ERR;
    endcase
    return code;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mtnc_front.sv -----
// ----------------------------------------------------------------------------
// mtnc_front
// Phase automaton: name length, stack pointer, store addressing and errors.
// ----------------------------------------------------------------------------
`default_nettype none

module mtnc_front #(
  parameter int unsigned MAX_NAME    = mtnc_pkg::MAX_NAME_DEF,
  parameter int unsigned STACK_DEPTH = mtnc_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LEN_W       = $clog2(MAX_NAME + 1),
  parameter int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1),
  parameter int unsigned SLOT_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  parameter int unsigned ADDR_W      =
    (STACK_DEPTH * MAX_NAME > 1) ? $clog2(STACK_DEPTH * MAX_NAME) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 acc_i,
  input  wire logic [7:0]           char_i,
  output mtnc_pkg::ctl_t            ctl_o,
  output logic      [3:0]           err_o,
  output logic      [2:0]           phase_o,
  output logic      [DEPTH_W-1:0]   depth_o,
  output logic      [LEN_W-1:0]     len_o,
  output logic                      name_we_o,
  output logic      [ADDR_W-1:0]    name_waddr_o,
  output logic      [ADDR_W-1:0]    name_raddr_o,
  output logic                      elen_we_o,
  output logic      [SLOT_W-1:0]    elen_waddr_o,
  output logic      [SLOT_W-1:0]    elen_raddr_o
);
  import mtnc_pkg::*;

  localparam int unsigned BASE_W = $clog2(STACK_DEPTH * MAX_NAME + 1);

  phase_e              phase_q, phase_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [DEPTH_W-1:0]  top_q, top_d;
  logic [BASE_W-1:0]   base_q, base_d;
  logic [3:0]          err_q, err_d;
  logic                len_full, stack_full, stack_empty;
  logic [BASE_W-1:0]   wsum, rsum;
  logic [DEPTH_W-1:0]  top_m1;

  assign len_full    = len_q >= LEN_W'(MAX_NAME);
  assign stack_full  = top_q >= DEPTH_W'(STACK_DEPTH);
  assign stack_empty = top_q == '0;
  assign wsum        = base_q + BASE_W'(len_q);
  assign rsum        = base_q - BASE_W'(MAX_NAME) + BASE_W'(len_q);
  assign top_m1      = top_q - DEPTH_W'(1);

  assign name_waddr_o = wsum[ADDR_W-1:0];
  assign name_raddr_o = rsum[ADDR_W-1:0];
  assign elen_waddr_o = top_q[SLOT_W-1:0];
  assign elen_raddr_o = top_m1[SLOT_W-1:0];

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    top_d     = top_q;
    base_d    = base_q;
    err_d     = err_q;
    name_we_o = 1'b0;
    elen_we_o = 1'b0;
    ctl_o     = '0;
    case (phase_q)
      PH_TEXT: begin
        if (char_i == CH_LT) phase_d = PH_TAG;
      end
      PH_TAG: begin
        if (is_letter(char_i)) begin
          phase_d = PH_OPEN;
          if (len_full) begin
            err_d   = ERR_LONG;
            phase_d = PH_ERR;
          end else begin
            name_we_o = !stack_full;
            len_d     = len_q + LEN_W'(1);
          end
        end else if (char_i == CH_SLASH) begin
          phase_d = PH_CLOSE;
        end
      end
      PH_OPEN: begin
        if (is_alnum(char_i)) begin
          if (len_full) begin
            err_d   = ERR_LONG;
            phase_d = PH_ERR;
          end else begin
            name_we_o = !stack_full;
            len_d     = len_q + LEN_W'(1);
          end
        end else if (is_space(char_i)) begin
          phase_d = PH_ATTR;
        end else if (char_i == CH_GT) begin
          if (stack_full) begin
            err_d   = ERR_OVER;
            phase_d = PH_ERR;
          end else begin
            elen_we_o = 1'b1;
            top_d     = top_q + DEPTH_W'(1);
            base_d    = base_q + BASE_W'(MAX_NAME);
            len_d     = '0;
            phase_d   = PH_TEXT;
          end
        end else begin
          err_d   = ERR_OPEN;
          phase_d = PH_ERR;
        end
      end
      PH_ATTR: begin
        if (char_i == CH_EQ) begin
          phase_d = PH_QUOTE;
        end else if (!(is_alnum(char_i) || char_i == CH_DASH)) begin
          err_d   = ERR_ATTR;
          phase_d = PH_ERR;
        end
      end
      PH_QUOTE: begin
        if (char_i == CH_QUOTE) begin
          phase_d = PH_VALUE;
        end else begin
          err_d   = ERR_NOQUOTE;
          phase_d = PH_ERR;
        end
      end
      PH_VALUE: begin
        if (char_i == CH_QUOTE) begin
          phase_d = PH_OPEN;
        end else if (char_i == CH_GT) begin
          err_d   = ERR_GTVAL;
          phase_d = PH_ERR;
        end
      end
      PH_CLOSE: begin
        if (is_alnum(char_i) || char_i == CH_DASH || char_i == CH_USCORE) begin
          if (len_full) begin
            err_d   = ERR_LONG;
            phase_d = PH_ERR;
          end else begin
            ctl_o.cmp      = 1'b1;
            ctl_o.top_zero = stack_empty;
            len_d          = len_q + LEN_W'(1);
          end
        end else if (char_i == CH_GT) begin
          if (stack_empty) begin
            err_d   = ERR_UNDER;
            phase_d = PH_ERR;
          end else begin
            ctl_o.pop = 1'b1;
            top_d     = top_m1;
            base_d    = base_q - BASE_W'(MAX_NAME);
            len_d     = '0;
            phase_d   = PH_TEXT;
          end
        end else begin
          err_d   = ERR_CLOSE;
          phase_d = PH_ERR;
        end
      end
      default: begin
      end
    endcase
  end

  assign err_o   = err_d;
  assign phase_o = phase_code(phase_d);
  assign depth_o = top_d;
  assign len_o   = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      len_q   <= '0;
      top_q   <= '0;
      base_q  <= '0;
      err_q   <= ERR_NONE;
    end else if (acc_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      top_q   <= top_d;
      base_q  <= base_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mtnc_store.sv -----
// ----------------------------------------------------------------------------
// mtnc_store
// Name byte memory and entry length memory, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module mtnc_store #(
  parameter int unsigned MAX_NAME    = mtnc_pkg::MAX_NAME_DEF,
  parameter int unsigned STACK_DEPTH = mtnc_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LEN_W       = $clog2(MAX_NAME + 1),
  parameter int unsigned SLOT_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  parameter int unsigned ADDR_W      =
    (STACK_DEPTH * MAX_NAME > 1) ? $clog2(STACK_DEPTH * MAX_NAME) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              acc_i,
  input  wire logic [7:0]        char_i,
  input  wire logic [LEN_W-1:0]  len_i,
  input  wire logic              name_we_i,
  input  wire logic [ADDR_W-1:0] name_waddr_i,
  input  wire logic [ADDR_W-1:0] name_raddr_i,
  input  wire logic              elen_we_i,
  input  wire logic [SLOT_W-1:0] elen_waddr_i,
  input  wire logic [SLOT_W-1:0] elen_raddr_i,
  output logic      [7:0]        name_rd_o,
  output logic      [LEN_W-1:0]  elen_rd_o
);
  import mtnc_pkg::*;

  localparam int unsigned NAME_DEPTH = STACK_DEPTH * MAX_NAME;

  logic [7:0]       name_mem [NAME_DEPTH];
  logic [LEN_W-1:0] elen_mem [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      if (name_we_i) name_mem[name_waddr_i] <= char_i;
      name_rd_o <= name_mem[name_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      if (elen_we_i) elen_mem[elen_waddr_i] <= len_i;
      elen_rd_o <= elen_mem[elen_raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mtnc_check.sv -----
// ----------------------------------------------------------------------------
// mtnc_check
// Close-name compare against read data, sticky mismatch, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtnc_check #(
  parameter int unsigned MAX_NAME    = mtnc_pkg::MAX_NAME_DEF,
  parameter int unsigned STACK_DEPTH = mtnc_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LEN_W       = $clog2(MAX_NAME + 1),
  parameter int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1),
  parameter int unsigned TDATA_W     = ((7 + DEPTH_W + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire logic [7:0]         char_i,
  input  wire mtnc_pkg::ctl_t     ctl_i,
  input  wire logic [3:0]         err_i,
  input  wire logic [2:0]         phase_i,
  input  wire logic [DEPTH_W-1:0] depth_i,
  input  wire logic [LEN_W-1:0]   len_i,
  input  wire logic [7:0]         name_rd_i,
  input  wire logic [LEN_W-1:0]   elen_rd_i,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic      [TDATA_W-1:0] m_data_o
);
  import mtnc_pkg::*;

  logic               s1_valid_q;
  ctl_t               s1_ctl_q;
  logic [7:0]         s1_char_q;
  logic [3:0]         s1_err_q;
  logic [2:0]         s1_phase_q;
  logic [DEPTH_W-1:0] s1_depth_q;
  logic [LEN_W-1:0]   s1_len_q;
  logic               mism_q, mism_d;
  logic               frozen_q, frozen_d;
  logic [DEPTH_W-1:0] frz_depth_q, frz_depth_d;
  logic               out_valid_q;
  logic [TDATA_W-1:0] out_data_q;
  logic               s1_adv, acc, byte_mism, pop_bad;
  logic [3:0]         res_err;
  logic [2:0]         res_phase;
  logic [DEPTH_W-1:0] res_depth;

  assign s1_adv    = s1_valid_q && (!out_valid_q || m_ready_i);
  assign s_ready_o = !s1_valid_q || s1_adv;
  assign acc       = s_valid_i && s_ready_o;

  assign byte_mism = s1_ctl_q.top_zero || (s1_len_q >= elen_rd_i) ||
                     (name_rd_i != s1_char_q);
  assign pop_bad   = s1_ctl_q.pop && (mism_q || (s1_len_q != elen_rd_i));

  always_comb begin
    res_err     = s1_err_q;
    res_phase   = s1_phase_q;
    res_depth   = s1_depth_q;
    mism_d      = mism_q;
    frozen_d    = frozen_q;
    frz_depth_d = frz_depth_q;
    if (frozen_q) begin
      res_err   = ERR_MISMATCH;
      res_phase = PC_ERR;
      res_depth = frz_depth_q;
    end else begin
      if (s1_ctl_q.cmp && byte_mism) mism_d = 1'b1;
      if (s1_ctl_q.pop) mism_d = 1'b0;
      if (pop_bad) begin
        res_err     = ERR_MISMATCH;
        res_phase   = PC_ERR;
        frozen_d    = 1'b1;
        frz_depth_d = s1_depth_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mism_q      <= 1'b0;
      frozen_q    <= 1'b0;
      frz_depth_q <= '0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        mism_q      <= mism_d;
        frozen_q    <= frozen_d;
        frz_depth_q <= frz_depth_d;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ctl_q   <= ctl_i;
      s1_char_q  <= char_i;
      s1_err_q   <= err_i;
      s1_phase_q <= phase_i;
      s1_depth_q <= depth_i;
      s1_len_q   <= len_i;
    end
    if (s1_adv) out_data_q <= TDATA_W'({res_depth, res_phase, res_err});
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- hdl/markup_tag_nesting_checker_unit.sv -----
// ----------------------------------------------------------------------------
// markup_tag_nesting_checker_unit
// Markup well-formedness checker with a memory-held stack of open tag names.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (lowest bit up)                   | tuser / tlast
//  s_axis   | in  | char_in[7:0]                            | none
//  m_axis   | out | error_code[3:0], phase[6:4], depth[..:7] | none
//
//  One byte per cycle sustained; the status is set by the compare stage
//  behind the registered read of the name and length memories and is
//  offered on m_axis from the output register that follows that stage.
//  Reset clears the automaton, stack pointer and pipeline; memories keep
//  their content. An output stall holds the compare stage and then input.
// ----------------------------------------------------------------------------
`default_nettype none

module markup_tag_nesting_checker_unit #(
  parameter int unsigned MAX_NAME    = mtnc_pkg::MAX_NAME_DEF,
  parameter int unsigned STACK_DEPTH = mtnc_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1),
  parameter int unsigned TDATA_W     = ((7 + DEPTH_W + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [7:0]         s_axis_tdata_i,  // char_in[7:0]
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic      [TDATA_W-1:0] m_axis_tdata_o   // error_code, phase, depth
);
  import mtnc_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_NAME + 1);
  localparam int unsigned SLOT_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned ADDR_W =
    (STACK_DEPTH * MAX_NAME > 1) ? $clog2(STACK_DEPTH * MAX_NAME) : 1;

  logic               acc;
  ctl_t               ctl;
  logic [3:0]         err;
  logic [2:0]         phase;
  logic [DEPTH_W-1:0] depth;
  logic [LEN_W-1:0]   len;
  logic               name_we, elen_we;
  logic [ADDR_W-1:0]  name_waddr, name_raddr;
  logic [SLOT_W-1:0]  elen_waddr, elen_raddr;
  logic [7:0]         name_rd;
  logic [LEN_W-1:0]   elen_rd;

  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  mtnc_front #(
    .MAX_NAME    (MAX_NAME),
    .STACK_DEPTH (STACK_DEPTH),
    .LEN_W       (LEN_W),
    .DEPTH_W     (DEPTH_W),
    .SLOT_W      (SLOT_W),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .char_i       (s_axis_tdata_i),
    .ctl_o        (ctl),
    .err_o        (err),
    .phase_o      (phase),
    .depth_o      (depth),
    .len_o        (len),
    .name_we_o    (name_we),
    .name_waddr_o (name_waddr),
    .name_raddr_o (name_raddr),
    .elen_we_o    (elen_we),
    .elen_waddr_o (elen_waddr),
    .elen_raddr_o (elen_raddr)
  );

  mtnc_store #(
    .MAX_NAME    (MAX_NAME),
    .STACK_DEPTH (STACK_DEPTH),
    .LEN_W       (LEN_W),
    .SLOT_W      (SLOT_W),
    .ADDR_W      (ADDR_W)
  ) u_store (
    .clk_i        (clk_i),
    .acc_i        (acc),
    .char_i       (s_axis_tdata_i),
    .len_i        (len),
    .name_we_i    (name_we),
    .name_waddr_i (name_waddr),
    .name_raddr_i (name_raddr),
    .elen_we_i    (elen_we),
    .elen_waddr_i (elen_waddr),
    .elen_raddr_i (elen_raddr),
    .name_rd_o    (name_rd),
    .elen_rd_o    (elen_rd)
  );

  mtnc_check #(
    .MAX_NAME    (MAX_NAME),
    .STACK_DEPTH (STACK_DEPTH),
    .LEN_W       (LEN_W),
    .DEPTH_W     (DEPTH_W),
    .TDATA_W     (TDATA_W)
  ) u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .char_i    (s_axis_tdata_i),
    .ctl_i     (ctl),
    .err_i     (err),
    .phase_i   (phase),
    .depth_i   (depth),
    .len_i     (len),
    .name_rd_i (name_rd),
    .elen_rd_i (elen_rd),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ----- bench/mtnc_status_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtnc_status_checker
// Follows both streams of the tag nesting checker. It keeps its own copy of
// the phase automaton and the name stack, works out the status word of every
// byte taken in, and compares each returned status with the oldest one due.
// ----------------------------------------------------------------------------
module mtnc_status_checker
  import mtnc_pkg::*;
#(
  parameter int unsigned MAX_NAME    = MAX_NAME_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1),
  parameter int unsigned TDATA_W     = ((7 + DEPTH_W + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  input  wire logic               s_tready_i,
  input  wire logic [7:0]         s_tdata_i,
  input  wire logic               m_tvalid_i,
  input  wire logic               m_tready_i,
  input  wire logic [TDATA_W-1:0] m_tdata_i,
  output int unsigned             fault_count_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic [3:0]         code;
    logic [2:0]         phase;
    logic [DEPTH_W-1:0] depth;
  } status_t;

  status_t     status_due [$];
  logic [7:0]  tag_text [STACK_DEPTH][MAX_NAME];
  int unsigned tag_len [STACK_DEPTH];
  logic [2:0]  ph;
  logic [3:0]  err;
  int unsigned cur_len;
  int unsigned open_cnt;
  bit          diverged;

  function automatic bit alpha_byte(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit alnum_byte(input logic [7:0] c);
    return alpha_byte(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic bit blank_byte(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  task automatic trip(input logic [3:0] code);
    err = code;
    ph  = PC_ERR;
  endtask

  // names typed while the stack is full go nowhere
  task automatic grow_open(input logic [7:0] c);
    if (cur_len >= MAX_NAME) begin
      trip(ERR_LONG);
    end else begin
      if (open_cnt < STACK_DEPTH) tag_text[open_cnt][cur_len] = c;
      cur_len++;
    end
  endtask

  task automatic nesting_step(input logic [7:0] c);
    status_t s;
    bit      bad;
    case (ph)
      PC_TEXT: begin
        if (c == CH_LT) ph = PC_TAG;
      end
      PC_TAG: begin
        if (alpha_byte(c)) begin
          ph = PC_OPEN;
          grow_open(c);
        end else if (c == CH_SLASH) begin
          ph = PC_CLOSE;
        end
      end
      PC_OPEN: begin
        if (alnum_byte(c)) begin
          grow_open(c);
        end else if (blank_byte(c)) begin
          ph = PC_ATTR;
        end else if (c == CH_GT) begin
          if (open_cnt >= STACK_DEPTH) begin
            trip(ERR_OVER);
          end else begin
            tag_len[open_cnt] = cur_len;
            open_cnt++;
            cur_len = 0;
            ph = PC_TEXT;
          end
        end else begin
          trip(ERR_OPEN);
        end
      end
      PC_ATTR: begin
        if (c == CH_EQ) ph = PC_QUOTE;
        else if (!(alnum_byte(c) || c == CH_DASH)) trip(ERR_ATTR);
      end
      PC_QUOTE: begin
        if (c == CH_QUOTE) ph = PC_VALUE;
        else trip(ERR_NOQUOTE);
      end
      PC_VALUE: begin
        if (c == CH_QUOTE) ph = PC_OPEN;
        else if (c == CH_GT) trip(ERR_GTVAL);
      end
      PC_CLOSE: begin
        if (alnum_byte(c) || c == CH_DASH || c == CH_USCORE) begin
          if (cur_len >= MAX_NAME) begin
            trip(ERR_LONG);
          end else begin
            if (open_cnt == 0) diverged = 1'b1;
            else if (cur_len >= tag_len[open_cnt-1] ||
                     tag_text[open_cnt-1][cur_len] != c) diverged = 1'b1;
            cur_len++;
          end
        end else if (c == CH_GT) begin
          if (open_cnt == 0) begin
            trip(ERR_UNDER);
          end else begin
            // pop even on a mismatch
            bad = diverged || cur_len != tag_len[open_cnt-1];
            open_cnt--;
            cur_len  = 0;
            diverged = 1'b0;
            if (bad) trip(ERR_MISMATCH);
            else ph = PC_TEXT;
          end
        end else begin
          trip(ERR_CLOSE);
        end
      end
      default: ;
    endcase
    s.code  = err;
    s.phase = ph;
    s.depth = open_cnt[DEPTH_W-1:0];
    status_due.push_back(s);
  endtask

  task automatic report_fault(input string what, input status_t want, input status_t got);
    fault_count_o++;
    if (fault_count_o <= 10)
      $display("%0t: %s: expected code %0d phase %0d depth %0d, got code %0d phase %0d depth %0d",
               $time, what, want.code, want.phase, want.depth,
               got.code, got.phase, got.depth);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    status_t     want;
    status_t     got;
    int unsigned i;
    int unsigned j;
    if (!rst_ni) begin
      status_due.delete();
      for (i = 0; i < STACK_DEPTH; i++) begin
        tag_len[i] = 0;
        for (j = 0; j < MAX_NAME; j++) tag_text[i][j] = 8'h00;
      end
      ph            = PC_TEXT;
      err           = ERR_NONE;
      cur_len       = 0;
      open_cnt      = 0;
      diverged      = 1'b0;
      fault_count_o = 0;
      pending_o     <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.code  = m_tdata_i[3:0];
        got.phase = m_tdata_i[6:4];
        got.depth = m_tdata_i[7 +: DEPTH_W];
        if (status_due.size() == 0) begin
          want = '0;
          report_fault("status with nothing due", want, got);
        end else begin
          want = status_due.pop_front();
          if (got.code !== want.code || got.phase !== want.phase ||
              got.depth !== want.depth)
            report_fault("status mismatch", want, got);
        end
      end
      if (s_tvalid_i && s_tready_i) nesting_step(s_tdata_i);
      pending_o <= status_due.size();
    end
  end

endmodule

// ----- bench/markup_tag_nesting_checker_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_tag_nesting_checker_unit_tb
// Feeds markup text into the tag nesting checker: a short opening sequence,
// then well-formed random tags, attributes and text that reach the full
// stack depth and the longest names, and finally one error case picked at
// random followed by bytes the block must ignore. Both sides idle at random.
// ----------------------------------------------------------------------------
module markup_tag_nesting_checker_unit_tb;
  import mtnc_pkg::*;

  localparam int unsigned MAX_NAME     = MAX_NAME_DEF;
  localparam int unsigned STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int unsigned DEPTH_W      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TDATA_W      = ((7 + DEPTH_W + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned WARMUP_LEN   = 24;

  // text extremes, tag start junk, attribute, bytes after a value, close
  localparam logic [WARMUP_LEN*8-1:0] WARMUP = {
    8'h00, 8'hFF, CH_LT, 8'h20, 8'h80, 8'h61, 8'h5A, 8'h39,
    8'h09, 8'h6B, CH_DASH, CH_EQ, CH_QUOTE, 8'h7F, CH_QUOTE, 8'h71,
    CH_GT, CH_LT, CH_SLASH, 8'h61, 8'h5A, 8'h39, 8'h71, CH_GT
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;   // char_in[7:0]
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;   // error_code[3:0], phase[6:4], depth[11:7]
  int unsigned        faults;
  int unsigned        pending;

  int unsigned        sent = 0;
  logic               quiet;
  logic [7:0]         gen_names [STACK_DEPTH][MAX_NAME];
  int unsigned        gen_lens [STACK_DEPTH];
  int unsigned        gen_depth = 0;

  assign quiet = (sent >= 1200) && (sent < 1500);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  markup_tag_nesting_checker_unit #(
    .MAX_NAME    (MAX_NAME),
    .STACK_DEPTH (STACK_DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  mtnc_status_checker #(
    .MAX_NAME    (MAX_NAME),
    .STACK_DEPTH (STACK_DEPTH)
  ) status_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .fault_count_o (faults),
    .pending_o     (pending)
  );

  function automatic bit word_byte(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [7:0] rand_letter();
    int unsigned k;
    k = $urandom_range(51);
    return 8'((k < 26) ? 8'h41 + k : 8'h61 + k - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int unsigned k;
    k = $urandom_range(61);
    return (k < 10) ? 8'(8'h30 + k) : rand_letter();
  endfunction

  function automatic int unsigned name_len_pick();
    return ($urandom_range(9) == 0) ? $urandom_range(MAX_NAME, 20) : $urandom_range(6, 1);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  // hold the input until every status due has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic emit_text();
    int unsigned n;
    int unsigned i;
    logic [7:0]  b;
    n = $urandom_range(4);
    for (i = 0; i < n; i++) begin
      do b = 8'($urandom_range(255)); while (b == CH_LT);
      put_byte(b);
    end
  endtask

  task automatic add_attribute();
    int unsigned k;
    int unsigned i;
    logic [7:0]  b;
    k = $urandom_range(5);
    put_byte((k == 5) ? 8'h20 : 8'(8'h09 + k));
    k = $urandom_range(4);
    for (i = 0; i < k; i++) put_byte(($urandom_range(7) == 0) ? CH_DASH : rand_alnum());
    put_byte(CH_EQ);
    put_byte(CH_QUOTE);
    k = $urandom_range(5);
    for (i = 0; i < k; i++) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_GT);
      put_byte(b);
    end
    put_byte(CH_QUOTE);
  endtask

  task automatic emit_open(input int unsigned len);
    int unsigned i;
    int unsigned n;
    logic [7:0]  b;
    put_byte(CH_LT);
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(2, 1);
      for (i = 0; i < n; i++) begin
        do b = 8'($urandom_range(255));
        while ((word_byte(b) && b > 8'h39) || b == CH_SLASH);
        put_byte(b);
      end
    end
    for (i = 0; i < len; i++) begin
      b = (i == 0) ? rand_letter() : rand_alnum();
      if (i > 0 && $urandom_range(99) < 12) add_attribute();
      gen_names[gen_depth][i] = b;
      put_byte(b);
    end
    if ($urandom_range(99) < 15) add_attribute();
    put_byte(CH_GT);
    gen_lens[gen_depth] = len;
    gen_depth++;
  endtask

  task automatic emit_close();
    int unsigned i;
    gen_depth--;
    put_byte(CH_LT);
    put_byte(CH_SLASH);
    for (i = 0; i < gen_lens[gen_depth]; i++) put_byte(gen_names[gen_depth][i]);
    put_byte(CH_GT);
  endtask

  initial begin : receive
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held && sent >= 400) begin
        held      = 1'b1;
        hold_left = 300;
        m_tready <= 1'b0;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 27);
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned goal;
    int unsigned slot;
    int unsigned fault_kind;
    bit          paused;
    logic [7:0]  b;
    logic [7:0]  c;
    paused = 1'b0;
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < WARMUP_LEN; i++) put_byte(WARMUP[(WARMUP_LEN-1-i)*8 +: 8]);
    drain();

    goal = STACK_DEPTH;
    while (sent < WARMUP_LEN + RANDOM_ITEMS) begin
      if (!paused && sent >= 1000) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(99) < 12) emit_text();
      else if (gen_depth < goal) emit_open(name_len_pick());
      else if (gen_depth > goal) emit_close();
      else goal = ($urandom_range(3) == 0) ? STACK_DEPTH : $urandom_range(STACK_DEPTH);
    end

    // end on one error, then bytes that must leave the status untouched
    fault_kind = $urandom_range(11);
    case (fault_kind)
      0: begin
        put_byte(CH_LT);
        put_byte(rand_letter());
        do b = 8'($urandom_range(255));
        while (word_byte(b) || b == CH_GT || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D));
        put_byte(b);
      end
      1: begin
        put_byte(CH_LT);
        put_byte(rand_letter());
        put_byte(8'h20);
        do b = 8'($urandom_range(255)); while (word_byte(b) || b == CH_DASH || b == CH_EQ);
        put_byte(b);
      end
      2: begin
        put_byte(CH_LT);
        put_byte(rand_letter());
        put_byte(8'h20);
        put_byte(CH_EQ);
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
        put_byte(b);
      end
      3: begin
        put_byte(CH_LT);
        put_byte(rand_letter());
        put_byte(8'h20);
        put_byte(CH_EQ);
        put_byte(CH_QUOTE);
        put_byte(CH_GT);
      end
      4: begin
        put_byte(CH_LT);
        put_byte(CH_SLASH);
        do b = 8'($urandom_range(255));
        while (word_byte(b) || b == CH_DASH || b == CH_USCORE || b == CH_GT);
        put_byte(b);
      end
      5, 6: begin
        if (gen_depth == 0) emit_open(name_len_pick());
        slot = gen_depth - 1;
        put_byte(CH_LT);
        put_byte(CH_SLASH);
        for (i = 0; i + 1 < gen_lens[slot]; i++) put_byte(gen_names[slot][i]);
        b = gen_names[slot][gen_lens[slot]-1];
        if (fault_kind == 5) begin
          if ($urandom_range(1) == 1) c = CH_USCORE;
          else do c = rand_alnum(); while (c == b);
          put_byte(c);
        end else if (gen_lens[slot] == 1) begin
          put_byte(b);
          put_byte(rand_alnum());
        end
        put_byte(CH_GT);
      end
      7: begin
        put_byte(CH_LT);
        put_byte(CH_SLASH);
        put_byte(CH_GT);
      end
      8: begin
        while (gen_depth > 0) emit_close();
        put_byte(CH_LT);
        put_byte(CH_SLASH);
        put_byte(rand_letter());
        put_byte(CH_GT);
      end
      9: begin
        while (gen_depth < STACK_DEPTH) emit_open($urandom_range(4, 1));
        put_byte(CH_LT);
        put_byte(rand_letter());
        put_byte(CH_GT);
      end
      10: begin
        put_byte(CH_LT);
        for (i = 0; i <= MAX_NAME; i++) put_byte(rand_letter());
      end
      default: begin
        put_byte(CH_LT);
        put_byte(CH_SLASH);
        for (i = 0; i <= MAX_NAME; i++) put_byte(rand_alnum());
      end
    endcase
    for (i = 0; i < 16; i++) put_byte(8'($urandom_range(255)));

    drain();
    repeat (8) @(posedge clk_i);
    if (faults == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
